// ===== sv/lru_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// Used by lru_ctrl, lru_dp and lru_page_replacement_top; depends on nothing.
package lru_pkg;

    // Frame store geometry.
    localparam int FRAMES       = 8;
    localparam int PAGE_BITS    = 16;
    localparam int FRAME_IDX_W  = $clog2(FRAMES);
    localparam int RANK_W       = $clog2(FRAMES);
    localparam int FRAME_CNT_W  = $clog2(FRAMES + 1);
    localparam int FAULT_W      = 32;

    // Configuration register reset value: frames taking part after reset.
    localparam logic [FRAME_CNT_W-1:0] FRAMES_IN_USE_RST = FRAME_CNT_W'(3);

    typedef logic [PAGE_BITS-1:0]   page_t;
    typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
    typedef logic [RANK_W-1:0]      rank_t;
    typedef logic [FRAME_CNT_W-1:0] frame_cnt_t;
    typedef logic [FAULT_W-1:0]     fault_cnt_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_page;
        logic do_lookup;
        logic do_update;
    } lru_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } lru_stat_t;

endpackage

// ===== sv/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: joins the controller and datapath.
// Depends on lru_pkg, lru_ctrl and lru_dp.
//
//   Channel   Direction  Handshake           Contents
//   s_        in         s_valid / s_ready   s_page: referenced page
//   m_        out        m_valid / m_ready   hit, frame_index, evicted_valid,
//                                            evicted_page, fault_count
//   cfg_      in         cfg_we              cfg_wdata: frames_in_use
//
// Each request passes a lookup step for the parallel tag compare and victim choice,
// then an update step for the recency and frame update that loads the result register.
// A new request is taken in the update cycle that retires the last one, so requests overlap.
// While a result waits in the output register the update step holds and input stalls.
// Synchronous active-low reset empties all frames, clears ranks and the fault count,
// and sets frames_in_use to three; no clearing pass is needed.
module lru_page_replacement_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  lru_pkg::frame_cnt_t     cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  lru_pkg::page_t          s_page,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output lru_pkg::frame_idx_t     m_frame_index,
    output logic                    m_evicted_valid,
    output lru_pkg::page_t          m_evicted_page,
    output lru_pkg::fault_cnt_t     m_fault_count
);
    import lru_pkg::*;

    lru_cmd_t  cmd;
    lru_stat_t stat;

    // Controller.
    lru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath.
    lru_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_page          (s_page),
        .cmd             (cmd),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_fault_count   (m_fault_count)
    );

endmodule

// ===== sv/lru_ctrl.sv =====
// Controller state machine for the LRU page replacement block.
// Depends on lru_pkg for the state type and the command and status structs.
module lru_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lru_pkg::lru_stat_t stat,
    output lru_pkg::lru_cmd_t  cmd
);
    import lru_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: lookup, then update once the result register can take the result.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (stat.out_free) begin
                    state_next = s_valid ? ST_LOOKUP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: a new request is taken while idle or in the cycle that retires the last one.
    always_comb begin
        s_ready       = 1'b0;
        cmd.do_lookup = 1'b0;
        cmd.do_update = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOOKUP: begin
                cmd.do_lookup = 1'b1;
            end
            ST_UPDATE: begin
                s_ready       = stat.out_free;
                cmd.do_update = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load_page = s_valid && s_ready;
    end

endmodule

// ===== sv/lru_dp.sv =====
// Datapath for the LRU page replacement block: frame store, recency ranks,
// fault counter, lookup and victim logic, and the result register. Depends on lru_pkg.
module lru_dp (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  lru_pkg::frame_cnt_t     cfg_wdata,
    input  lru_pkg::page_t          s_page,
    input  lru_pkg::lru_cmd_t       cmd,
    output lru_pkg::lru_stat_t      stat,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output lru_pkg::frame_idx_t     m_frame_index,
    output logic                    m_evicted_valid,
    output lru_pkg::page_t          m_evicted_page,
    output lru_pkg::fault_cnt_t     m_fault_count
);
    import lru_pkg::*;

    // Configuration and request registers.
    frame_cnt_t frames_in_use_reg;
    page_t      page_reg;

    // Frame state.
    page_t      frame_page_reg [FRAMES];
    logic       frame_valid_reg [FRAMES];
    rank_t      rank_reg [FRAMES];
    fault_cnt_t faults_reg;

    // Lookup results held for the update step.
    logic       hit_reg;
    logic       evict_reg;
    frame_idx_t sel_reg;

    // Result register.
    logic       m_valid_reg;
    logic       m_hit_reg;
    frame_idx_t m_frame_index_reg;
    logic       m_evicted_valid_reg;
    page_t      m_evicted_page_reg;
    fault_cnt_t m_fault_count_reg;

    // Lookup logic.
    frame_cnt_t n_eff;
    logic       hit_found;
    frame_idx_t hit_idx;
    logic       empty_found;
    frame_idx_t empty_idx;
    frame_idx_t victim_idx;
    rank_t      victim_rank;

    // Update logic.
    frame_cnt_t old_rank;
    fault_cnt_t faults_next;
    page_t      ev_page;

    // Frame count clamped to one through FRAMES.
    always_comb begin
        if (frames_in_use_reg == '0) begin
            n_eff = FRAME_CNT_W'(1);
        end else if (frames_in_use_reg > FRAME_CNT_W'(FRAMES)) begin
            n_eff = FRAME_CNT_W'(FRAMES);
        end else begin
            n_eff = frames_in_use_reg;
        end
    end

    // Parallel tag compare and empty search; the lowest frame wins.
    always_comb begin
        hit_found   = 1'b0;
        hit_idx     = '0;
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int k = FRAMES - 1; k >= 0; k--) begin
            if (FRAME_CNT_W'(k) < n_eff) begin
                if (frame_valid_reg[k] && frame_page_reg[k] == page_reg) begin
                    hit_found = 1'b1;
                    hit_idx   = FRAME_IDX_W'(k);
                end
                if (!frame_valid_reg[k]) begin
                    empty_found = 1'b1;
                    empty_idx   = FRAME_IDX_W'(k);
                end
            end
        end
    end

    // Least recent frame among those taking part; ties go to the lower frame.
    always_comb begin
        victim_idx  = '0;
        victim_rank = rank_reg[0];
        for (int k = 1; k < FRAMES; k++) begin
            if (FRAME_CNT_W'(k) < n_eff && rank_reg[k] > victim_rank) begin
                victim_idx  = FRAME_IDX_W'(k);
                victim_rank = rank_reg[k];
            end
        end
    end

    // Configuration register and request capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_in_use_reg <= FRAMES_IN_USE_RST;
        end else if (cfg_we) begin
            frames_in_use_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_page) begin
            page_reg <= s_page;
        end
    end

    // Lookup step: choose the frame and remember whether it is a hit or an eviction.
    always_ff @(posedge aclk) begin
        if (cmd.do_lookup) begin
            hit_reg   <= hit_found;
            evict_reg <= !hit_found && !empty_found;
            if (hit_found) begin
                sel_reg <= hit_idx;
            end else if (empty_found) begin
                sel_reg <= empty_idx;
            end else begin
                sel_reg <= victim_idx;
            end
        end
    end

    // Values for the update step.
    assign old_rank    = frame_valid_reg[sel_reg] ? FRAME_CNT_W'(rank_reg[sel_reg])
                                                  : FRAME_CNT_W'(FRAMES);
    assign faults_next = (hit_reg || faults_reg == '1) ? faults_reg : faults_reg + 1'b1;
    assign ev_page     = evict_reg ? frame_page_reg[sel_reg] : '0;

    // Frame pages: written on a fault, no reset.
    always_ff @(posedge aclk) begin
        if (cmd.do_update && !hit_reg) begin
            frame_page_reg[sel_reg] <= page_reg;
        end
    end

    // Recency ranks, valid bits and the fault counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < FRAMES; k++) begin
                frame_valid_reg[k] <= 1'b0;
                rank_reg[k]        <= '0;
            end
            faults_reg <= '0;
        end else if (cmd.do_update) begin
            for (int k = 0; k < FRAMES; k++) begin
                if (FRAME_IDX_W'(k) == sel_reg) begin
                    rank_reg[k]        <= '0;
                    frame_valid_reg[k] <= 1'b1;
                end else if (frame_valid_reg[k] &&
                             FRAME_CNT_W'(rank_reg[k]) < old_rank) begin
                    rank_reg[k] <= rank_reg[k] + 1'b1;
                end
            end
            faults_reg <= faults_next;
        end
    end

    // Result register: loaded by the update step, emptied when the result is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.do_update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_update) begin
            m_hit_reg           <= hit_reg;
            m_frame_index_reg   <= sel_reg;
            m_evicted_valid_reg <= evict_reg;
            m_evicted_page_reg  <= ev_page;
            m_fault_count_reg   <= faults_next;
        end
    end

    assign stat.out_free    = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_frame_index    = m_frame_index_reg;
    assign m_evicted_valid  = m_evicted_valid_reg;
    assign m_evicted_page   = m_evicted_page_reg;
    assign m_fault_count    = m_fault_count_reg;

    // The fault counter never goes backward.
    a_faults_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_update |=> faults_reg >= $past(faults_reg))
        else $error("fault counter decreased");

    // A fault adds one unless the counter is full.
    a_fault_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_update && !hit_reg) |=>
            (faults_reg == $past(faults_reg) + 1'b1 || $past(faults_reg) == '1))
        else $error("fault not counted");

    // A hit never evicts a page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_evicted_valid_reg))
        else $error("hit reported with an eviction");

    // The updated frame becomes the most recent and valid.
    a_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_update |=> (rank_reg[$past(sel_reg)] == '0 && frame_valid_reg[$past(sel_reg)]))
        else $error("touched frame not most recent");

endmodule
